### rtl/lrast_pkg.sv
// Shared types and constants of the line rasterizer.
package lrast_pkg;

  localparam int COORD_BITS  = 6;
  localparam int WORD_BITS   = 32;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int MAX_PIXELS  = 64;
  localparam int CNT_BITS    = $clog2(MAX_PIXELS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    coord_t                start_x;
    coord_t                start_y;
    coord_t                end_x;
    coord_t                end_y;
    logic [WORD_BITS-1:0]  pixel_value;
  } in_word_t;

  typedef struct packed {
    coord_t                pixel_x;
    coord_t                pixel_y;
    logic [WORD_BITS-1:0]  pixel_word;
    logic                  final_pixel;
  } out_word_t;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic y_major;
  } dir_t;

  typedef struct packed {
    coord_t                start_x;
    coord_t                start_y;
    coord_t                span_major;
    coord_t                span_minor;
    err_t                  err_init;
    dir_t                  dir;
    logic [WORD_BITS-1:0]  word;
  } job_t;

endpackage

### rtl/lrast_front.sv
// Front end: classifies a line command into spans, directions and initial error.
module lrast_front (
  input  lrast_pkg::in_word_t in_data,
  output lrast_pkg::job_t     job
);

  lrast_pkg::coord_t ax;
  lrast_pkg::coord_t ay;
  logic              x_neg;
  logic              y_neg;
  logic              y_major;

  always_comb begin
    x_neg   = in_data.end_x < in_data.start_x;
    y_neg   = in_data.end_y < in_data.start_y;
    ax      = x_neg ? in_data.start_x - in_data.end_x : in_data.end_x - in_data.start_x;
    ay      = y_neg ? in_data.start_y - in_data.end_y : in_data.end_y - in_data.start_y;
    // Equal spans keep x as the major axis.
    y_major = ay > ax;

    job.start_x     = in_data.start_x;
    job.start_y     = in_data.start_y;
    job.span_major  = y_major ? ay : ax;
    job.span_minor  = y_major ? ax : ay;
    job.err_init    = lrast_pkg::err_t'({2'b00, job.span_minor, 1'b0})
                    - lrast_pkg::err_t'({3'b000, job.span_major});
    job.dir.x_neg   = x_neg;
    job.dir.y_neg   = y_neg;
    job.dir.y_major = y_major;
    job.word        = in_data.pixel_value;
  end

endmodule

### rtl/lrast_queue.sv
// Short queue of classified line jobs between the front end and the stepper.
module lrast_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  lrast_pkg::job_t wr_job,
  output logic            full,
  input  logic            rd_en,
  output lrast_pkg::job_t rd_job,
  output logic            empty
);

  lrast_pkg::job_t                   mem_r [lrast_pkg::QUEUE_DEPTH];
  logic [lrast_pkg::QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lrast_pkg::QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lrast_pkg::QPTR_BITS:0]     cnt_r, cnt_nxt;

  assign full   = cnt_r == (lrast_pkg::QPTR_BITS+1)'(lrast_pkg::QUEUE_DEPTH);
  assign empty  = cnt_r == '0;
  assign rd_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lrast_pkg::QPTR_BITS'(wr_en);
    rd_ptr_nxt = rd_ptr_r + lrast_pkg::QPTR_BITS'(rd_en);
    cnt_nxt    = cnt_r + (lrast_pkg::QPTR_BITS+1)'(wr_en)
               - (lrast_pkg::QPTR_BITS+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

### rtl/lrast_back.sv
// Back end: walks a line into an output register, a pixel per cycle unless held.
module lrast_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  lrast_pkg::job_t       job,
  output logic                  job_pop,
  output lrast_pkg::out_word_t  out_data,
  output logic                  empty,
  input  logic                  pop
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  lrast_pkg::coord_t               cur_x_r, cur_x_nxt;
  lrast_pkg::coord_t               cur_y_r, cur_y_nxt;
  lrast_pkg::err_t                 err_r, err_nxt;
  lrast_pkg::coord_t               major_r, major_nxt;
  lrast_pkg::coord_t               minor_r, minor_nxt;
  lrast_pkg::coord_t               steps_r, steps_nxt;
  logic [lrast_pkg::CNT_BITS-1:0]  cnt_r, cnt_nxt;
  lrast_pkg::dir_t                 dir_r, dir_nxt;
  logic [lrast_pkg::WORD_BITS-1:0] word_r, word_nxt;
  lrast_pkg::out_word_t            out_r, out_nxt;
  logic                            out_vld_r, out_vld_nxt;

  logic              advance;
  logic              last;
  lrast_pkg::coord_t step_x;
  lrast_pkg::coord_t step_y;
  lrast_pkg::err_t   twice_major;
  lrast_pkg::err_t   twice_minor;

  assign empty    = !out_vld_r;
  assign out_data = out_r;
  // The output register can take a new word when it is free or being drained.
  assign advance  = !out_vld_r || pop;
  assign job_pop  = (state_r == ST_IDLE) && !job_empty;

  always_comb begin
    last        = (steps_r == '0)
               || (cnt_r == lrast_pkg::CNT_BITS'(lrast_pkg::MAX_PIXELS - 1));
    step_x      = dir_r.x_neg ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    step_y      = dir_r.y_neg ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    twice_major = lrast_pkg::err_t'({2'b00, major_r, 1'b0});
    twice_minor = lrast_pkg::err_t'({2'b00, minor_r, 1'b0});

    state_nxt   = state_r;
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    err_nxt     = err_r;
    major_nxt   = major_r;
    minor_nxt   = minor_r;
    steps_nxt   = steps_r;
    cnt_nxt     = cnt_r;
    dir_nxt     = dir_r;
    word_nxt    = word_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !pop;

    case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          cur_x_nxt = job.start_x;
          cur_y_nxt = job.start_y;
          err_nxt   = job.err_init;
          major_nxt = job.span_major;
          minor_nxt = job.span_minor;
          steps_nxt = job.span_major;
          cnt_nxt   = '0;
          dir_nxt   = job.dir;
          word_nxt  = job.word;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          out_nxt.pixel_x     = cur_x_r;
          out_nxt.pixel_y     = cur_y_r;
          out_nxt.pixel_word  = word_r;
          out_nxt.final_pixel = last;
          out_vld_nxt         = 1'b1;
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            // A strictly positive error moves the minor coordinate as well.
            if (err_r > 0) begin
              if (dir_r.y_major) begin
                cur_x_nxt = step_x;
              end else begin
                cur_y_nxt = step_y;
              end
              err_nxt = err_r - twice_major + twice_minor;
            end else begin
              err_nxt = err_r + twice_minor;
            end
            if (dir_r.y_major) begin
              cur_y_nxt = step_y;
            end else begin
              cur_x_nxt = step_x;
            end
            steps_nxt = steps_r - 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    err_r   <= err_nxt;
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    steps_r <= steps_nxt;
    cnt_r   <= cnt_nxt;
    dir_r   <= dir_nxt;
    word_r  <= word_nxt;
    out_r   <= out_nxt;
  end

endmodule

### rtl/line_rasterizer_unit.sv
// Top level of the Bresenham line rasterizer.
// Each command word (start point, end point, pixel word) is turned into the pixels of the
// line from start to end inclusive, one output word per pixel in drawing order, with
// final_pixel set on the last one; a zero-length line gives a single pixel. The front end
// classifies a command in the cycle it is pushed and parks it in a two-entry queue; the
// stepper loads a queued line and then emits one pixel per cycle while pop keeps up, a
// rate set by the stepper's error-term loop. A line has up to 64 pixels at 6-bit
// coordinates. Commands may be pushed while an earlier line is still being drawn, until
// the queue is full.
module line_rasterizer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  lrast_pkg::in_word_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output lrast_pkg::out_word_t out_data
);

  lrast_pkg::job_t front_job;
  lrast_pkg::job_t queue_job;
  logic            queue_empty;
  logic            queue_pop;

  lrast_front u_front (
    .in_data (in_data),
    .job     (front_job)
  );

  lrast_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push && !full),
    .wr_job (front_job),
    .full   (full),
    .rd_en  (queue_pop),
    .rd_job (queue_job),
    .empty  (queue_empty)
  );

  lrast_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (queue_empty),
    .job       (queue_job),
    .job_pop   (queue_pop),
    .out_data  (out_data),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

### tb/tb_line_rasterizer_unit.sv
// Self-checking testbench for the Bresenham line rasterizer top level.
`timescale 1ns / 100ps

module tb_line_rasterizer_unit;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int IDLE_PCT     = 22;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int COORD_MAX    = (1 << lrast_pkg::COORD_BITS) - 1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  lrast_pkg::in_word_t  in_data = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  lrast_pkg::out_word_t out_data;

  lrast_pkg::out_word_t pending_pixels[$];
  int                   pixel_errors = 0;
  bit                   hold_req = 1'b0;
  int                   hold_cnt = 0;
  bit                   gaps_on = 1'b1;

  line_rasterizer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic lrast_pkg::in_word_t make_line(int x0, int y0, int x1, int y1,
                                                    logic [lrast_pkg::WORD_BITS-1:0] value);
    lrast_pkg::in_word_t w;
    w.start_x     = lrast_pkg::coord_t'(x0);
    w.start_y     = lrast_pkg::coord_t'(y0);
    w.end_x       = lrast_pkg::coord_t'(x1);
    w.end_y       = lrast_pkg::coord_t'(y1);
    w.pixel_value = value;
    return w;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Most random lines are short so the run stays fast; the rest may run anywhere on the grid.
  function automatic lrast_pkg::in_word_t random_line();
    int x0, y0;
    x0 = $urandom_range(COORD_MAX);
    y0 = $urandom_range(COORD_MAX);
    if ($urandom_range(99) < 70)
      return make_line(x0, y0, clamp_coord(x0 + int'($urandom_range(16)) - 8),
                       clamp_coord(y0 + int'($urandom_range(16)) - 8), $urandom);
    return make_line(x0, y0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom);
  endfunction

  // Walks the line with a major-axis error term and queues every pixel it draws.
  function automatic void predict_line(lrast_pkg::in_word_t w);
    int                   x, y, dx, dy, sx, sy, ax, ay, major, minor, err, left, n;
    bit                   y_major, last;
    lrast_pkg::out_word_t p;
    x       = int'(w.start_x);
    y       = int'(w.start_y);
    dx      = int'(w.end_x) - x;
    dy      = int'(w.end_y) - y;
    sx      = (dx < 0) ? -1 : 1;
    sy      = (dy < 0) ? -1 : 1;
    ax      = (dx < 0) ? -dx : dx;
    ay      = (dy < 0) ? -dy : dy;
    y_major = (ay > ax);
    major   = y_major ? ay : ax;
    minor   = y_major ? ax : ay;
    err     = 2 * minor - major;
    left    = major;
    n       = 0;
    do begin
      last          = (left == 0) || (n == lrast_pkg::MAX_PIXELS - 1);
      p.pixel_x     = lrast_pkg::coord_t'(x);
      p.pixel_y     = lrast_pkg::coord_t'(y);
      p.pixel_word  = w.pixel_value;
      p.final_pixel = last;
      pending_pixels.push_back(p);
      n++;
      if (!last) begin
        if (err > 0) begin
          if (y_major) x += sx;
          else y += sy;
          err -= 2 * major;
        end
        err += 2 * minor;
        if (y_major) y += sy;
        else x += sx;
        left--;
      end
    end while (!last);
  endfunction

  function automatic void note_mismatch(string msg);
    pixel_errors++;
    if (pixel_errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // Offers one command word from a falling edge and returns at the edge that takes it.
  task automatic send_line(lrast_pkg::in_word_t w);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      push    = 1'b0;
      in_data = lrast_pkg::in_word_t'({$urandom, $urandom});
      @(negedge clk);
    end
    push    = 1'b1;
    in_data = w;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_line(w);
  endtask

  // Receiver: drives pop on falling edges; once a hold-off is requested it counts it out here.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop = 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      pop = 1'b0;
      hold_cnt++;
    end else begin
      pop = !(gaps_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_pixels
    lrast_pkg::out_word_t want;
    if (rst_n && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel x=%0d y=%0d word=%h final=%b",
                                out_data.pixel_x, out_data.pixel_y,
                                out_data.pixel_word, out_data.final_pixel));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
            out_data.pixel_word !== want.pixel_word ||
            out_data.final_pixel !== want.final_pixel)
          note_mismatch($sformatf(
            "expected x=%0d y=%0d word=%h final=%b, got x=%0d y=%0d word=%h final=%b",
            want.pixel_x, want.pixel_y, want.pixel_word, want.final_pixel,
            out_data.pixel_x, out_data.pixel_y, out_data.pixel_word,
            out_data.final_pixel));
      end
    end
  end

  // Corners, full-length axes and diagonals, every octant, and error terms that hit zero.
  task automatic test_directed_lines();
    send_line(make_line(0, 0, 0, 0, 32'h0000_0000));
    send_line(make_line(63, 63, 63, 63, 32'hFFFF_FFFF));
    send_line(make_line(0, 0, 63, 0, 32'hA5A5_A5A5));
    send_line(make_line(63, 63, 0, 63, 32'h5A5A_5A5A));
    send_line(make_line(0, 0, 0, 63, $urandom));
    send_line(make_line(63, 63, 63, 0, $urandom));
    send_line(make_line(0, 0, 63, 63, $urandom));
    send_line(make_line(63, 0, 0, 63, $urandom));
    send_line(make_line(0, 63, 63, 0, $urandom));
    send_line(make_line(63, 63, 0, 0, $urandom));
    send_line(make_line(10, 10, 12, 11, $urandom));
    send_line(make_line(5, 7, 7, 6, $urandom));
    send_line(make_line(20, 20, 30, 24, $urandom));
    send_line(make_line(20, 20, 24, 30, $urandom));
    send_line(make_line(20, 20, 10, 24, $urandom));
    send_line(make_line(20, 20, 16, 30, $urandom));
    send_line(make_line(20, 20, 30, 16, $urandom));
    send_line(make_line(20, 20, 24, 10, $urandom));
    send_line(make_line(20, 20, 10, 16, $urandom));
    send_line(make_line(20, 20, 16, 10, $urandom));
    send_line(make_line(0, 0, 1, 63, $urandom));
    send_line(make_line(63, 0, 0, 1, $urandom));
  endtask

  task automatic test_random_lines(int count);
    repeat (count) send_line(random_line());
  endtask

  // Back-to-back traffic on both sides with no idle cycles at all.
  task automatic test_streaming(int count);
    gaps_on = 1'b0;
    repeat (count) send_line(random_line());
    gaps_on = 1'b1;
  endtask

  // The receiver stops for a long stretch while long lines keep coming, so full must rise.
  task automatic test_backpressure(int count);
    hold_req = 1'b1;
    repeat (count)
      send_line(make_line($urandom_range(7), $urandom_range(COORD_MAX),
                          COORD_MAX - $urandom_range(7), $urandom_range(COORD_MAX),
                          $urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_lines();
    test_random_lines(340);
    test_streaming(60);
    test_backpressure(30);
    @(negedge clk);
    push = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

endmodule
